>>> src/he_pkg.sv
`timescale 1ns / 1ps

package he_pkg;

  // Default sizing
  localparam int unsigned MAX_PIXELS_DEF = 1048576;
  localparam int unsigned LEVELS_DEF     = 256;

  // Grey levels and remapped levels are 8 bits; the scale 255 is 2**SCALE_W - 1
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned SCALE_W = 8;

  // Action codes
  typedef logic [1:0] action_t;
  localparam action_t ACT_CLEAR = 2'd0;
  localparam action_t ACT_ACCUM = 2'd1;
  localparam action_t ACT_MAP   = 2'd2;

  typedef struct packed {
    action_t              action;
    logic [LEVEL_W-1:0]   pixel_level;
  } he_req_t;

  typedef struct packed {
    logic [SCALE_W-1:0]   equalized_level;
    logic                 empty_res;
    logic                 overflow;
  } he_res_t;

  // Requests to the histogram store
  typedef struct packed {
    logic inc;  // read-modify-write increment of one bin
    logic clr;  // write zero to one bin
    logic rd;   // plain read for the table rebuild
  } bin_ctl_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_RB_READ,
    ST_RB_SUM,
    ST_RB_START,
    ST_RB_DIV,
    ST_RB_LOOK
  } st_e;

endpackage

>>> src/he_bins.sv
`timescale 1ns / 1ps

module he_bins import he_pkg::*; #(
  parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF,
  parameter int unsigned LEVELS     = LEVELS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  bin_ctl_t                             ctl_i,
  input  logic [$clog2(LEVELS)-1:0]            addr_i,
  output logic [$clog2(MAX_PIXELS+1)-1:0]      rd_data_o
);

  localparam int unsigned CNT_W = $clog2(MAX_PIXELS + 1);
  localparam int unsigned LVL_W = $clog2(LEVELS);

  logic [CNT_W-1:0] mem [LEVELS];

  logic             inc_q;
  logic [LVL_W-1:0] inc_addr_q;
  logic [CNT_W-1:0] rd_q;
  logic             last_we_q;
  logic [LVL_W-1:0] last_addr_q;
  logic [CNT_W-1:0] last_data_q;

  logic             re;
  logic             we;
  logic [LVL_W-1:0] waddr;
  logic [CNT_W-1:0] wdata;
  logic [CNT_W-1:0] inc_base;

  assign re = ctl_i.inc | ctl_i.rd;

  // Take the word written at the edge of the read when it hit the same bin
  assign inc_base = (last_we_q && (last_addr_q == inc_addr_q)) ? last_data_q : rd_q;

  assign we    = ctl_i.clr | inc_q;
  assign waddr = ctl_i.clr ? addr_i : inc_addr_q;
  assign wdata = ctl_i.clr ? '0 : inc_base + 1'b1;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_q     <= 1'b0;
      last_we_q <= 1'b0;
    end else begin
      inc_q     <= ctl_i.inc;
      last_we_q <= we;
    end
  end

  always_ff @(posedge clk_i) begin
    inc_addr_q  <= addr_i;
    last_addr_q <= waddr;
    last_data_q <= wdata;
  end

  assign rd_data_o = rd_q;

endmodule

>>> src/he_div.sv
`timescale 1ns / 1ps

module he_div import he_pkg::*; #(
  parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      start_i,
  input  logic [$clog2(MAX_PIXELS+1)+SCALE_W-1:0]   dividend_i,
  input  logic [$clog2(MAX_PIXELS+1)-1:0]           divisor_i,
  output logic                                      done_o,
  output logic [SCALE_W-1:0]                        quot_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_PIXELS + 1);
  localparam int unsigned NUM_W  = CNT_W + SCALE_W;
  localparam int unsigned STEP_W = $clog2(SCALE_W);

  logic               run_q;
  logic               done_q;
  logic [STEP_W-1:0]  step_q;
  logic [CNT_W-1:0]   rem_q;
  logic [SCALE_W-1:0] low_q;
  logic [SCALE_W-1:0] quot_q;
  logic [CNT_W-1:0]   div_q;

  logic [CNT_W:0]     trial;
  logic               ge;
  logic [CNT_W:0]     rem_next;

  // One quotient bit per cycle; the quotient fits in SCALE_W bits since
  // the dividend is below 2**SCALE_W times the divisor.
  assign trial    = {rem_q, low_q[SCALE_W-1]};
  assign ge       = trial >= {1'b0, div_q};
  assign rem_next = ge ? trial - {1'b0, div_q} : trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(SCALE_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[NUM_W-1:SCALE_W];
      low_q <= dividend_i[SCALE_W-1:0];
      div_q <= divisor_i;
    end else if (run_q) begin
      rem_q  <= rem_next[CNT_W-1:0];
      low_q  <= {low_q[SCALE_W-2:0], 1'b0};
      quot_q <= {quot_q[SCALE_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

>>> src/histogram_equalizer.sv
`timescale 1ns / 1ps
// Histogram equalizer for 8-bit grey levels.
// Command channel: req_i (action, pixel_level) is taken at a rising edge with
// start high and busy low. Clear empties the histogram, accumulate adds one
// pixel to its bin, map answers with the equalized level.
// Result channel: one word per map on res_o, marked by res_valid_o for exactly
// one cycle; the receiver cannot stall it, so it must take every word.
// Accumulate: one word per cycle back to back; a read-modify-write pipeline
// on the histogram RAM forwards the last write when the same bin repeats.
// Map with an up-to-date table (or an empty histogram): result in the cycle
// after acceptance, one word per cycle.
// The first map after an accumulate that adds a pixel rebuilds the remap
// table: each bin is read and added to a running sum, which is scaled by 255
// and divided by the pixel count in an 8-step serial divider, with busy high.
// The result is then read from the table in the final look-up state.
// Clear sweeps the histogram RAM one bin per cycle, with busy high.
// Reset runs the same sweep, so busy stays high after rst_ni releases until
// the sweep ends; the overflow flag clears and the table counts as stale.

module histogram_equalizer import he_pkg::*; #(
  parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF,
  parameter int unsigned LEVELS     = LEVELS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  he_req_t req_i,
  output logic    res_valid_o,
  output he_res_t res_o
);

  localparam int unsigned CNT_W = $clog2(MAX_PIXELS + 1);
  localparam int unsigned LVL_W = $clog2(LEVELS);
  localparam int unsigned NUM_W = CNT_W + SCALE_W;
  localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(LEVELS - 1);

  // Control state
  st_e              state_q, state_d;
  logic [LVL_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] pc_q, pc_d;
  logic             ovf_q, ovf_d;
  logic             stale_q, stale_d;
  logic             res_valid_q, res_valid_d;

  // Payload registers
  logic [LVL_W-1:0]   lvl_q;
  logic [CNT_W-1:0]   running_q, running_d;
  logic               res_empty_q, res_empty_d;
  logic               res_ovf_q, res_ovf_d;
  logic [SCALE_W-1:0] remap_rd_q;

  // Remap table; contents undefined until the first rebuild
  logic [SCALE_W-1:0] remap_mem [LEVELS];

  logic             accept;
  logic             is_clear;
  logic             is_accum;
  logic             is_map;
  logic             pc_zero;
  logic             pc_full;
  logic [LVL_W-1:0] lvl_in;

  bin_ctl_t         bin_ctl;
  logic [LVL_W-1:0] bin_addr;
  logic [CNT_W-1:0] bin_rd;

  logic               div_start;
  logic               div_done;
  logic [SCALE_W-1:0] div_quot;
  logic [NUM_W-1:0]   dividend;

  logic             remap_we;
  logic             remap_re;
  logic [LVL_W-1:0] remap_raddr;

  assign accept   = start && !busy;
  assign is_clear = accept && (req_i.action == ACT_CLEAR);
  assign is_accum = accept && (req_i.action == ACT_ACCUM);
  assign is_map   = accept && (req_i.action == ACT_MAP);
  assign pc_zero  = (pc_q == '0);
  assign pc_full  = (pc_q == CNT_W'(MAX_PIXELS));

  // Saturate levels beyond the last bin
  always_comb begin
    if (int'(req_i.pixel_level) >= int'(LEVELS)) begin
      lvl_in = LAST_LVL;
    end else begin
      lvl_in = LVL_W'(req_i.pixel_level);
    end
  end

  // running * 255 as a shift and a subtract
  assign dividend = {running_q, {SCALE_W{1'b0}}} - NUM_W'(running_q);

  he_bins #(
    .MAX_PIXELS (MAX_PIXELS),
    .LEVELS     (LEVELS)
  ) u_bins (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (bin_ctl),
    .addr_i    (bin_addr),
    .rd_data_o (bin_rd)
  );

  he_div #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (pc_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_SWEEP: begin
        if (idx_q == LAST_LVL) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (is_clear) begin
          state_d = ST_SWEEP;
        end else if (is_map && !pc_zero && stale_q) begin
          state_d = ST_RB_READ;
        end
      end
      ST_RB_READ:  state_d = ST_RB_SUM;
      ST_RB_SUM:   state_d = ST_RB_START;
      ST_RB_START: state_d = ST_RB_DIV;
      ST_RB_DIV: begin
        if (div_done) begin
          state_d = (idx_q == LAST_LVL) ? ST_RB_LOOK : ST_RB_READ;
        end
      end
      ST_RB_LOOK:  state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // State outputs: memory ports and divider start
  always_comb begin
    busy        = 1'b1;
    bin_ctl     = '0;
    bin_addr    = idx_q;
    div_start   = 1'b0;
    remap_we    = 1'b0;
    remap_re    = 1'b0;
    remap_raddr = lvl_q;
    case (state_q)
      ST_SWEEP: begin
        bin_ctl.clr = 1'b1;
      end
      ST_IDLE: begin
        busy        = 1'b0;
        bin_addr    = lvl_in;
        bin_ctl.inc = is_accum && !pc_full;
        remap_re    = is_map && !pc_zero && !stale_q;
        remap_raddr = lvl_in;
      end
      ST_RB_READ: begin
        bin_ctl.rd = 1'b1;
      end
      ST_RB_START: begin
        div_start = 1'b1;
      end
      ST_RB_DIV: begin
        remap_we = div_done;
      end
      ST_RB_LOOK: begin
        remap_re = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // Datapath and flag updates
  always_comb begin
    idx_d       = idx_q;
    pc_d        = pc_q;
    ovf_d       = ovf_q;
    stale_d     = stale_q;
    running_d   = running_q;
    res_valid_d = 1'b0;
    res_empty_d = 1'b0;
    res_ovf_d   = ovf_q;
    case (state_q)
      ST_SWEEP: begin
        idx_d = (idx_q == LAST_LVL) ? '0 : idx_q + 1'b1;
      end
      ST_IDLE: begin
        idx_d     = '0;
        running_d = '0;
        if (is_clear) begin
          pc_d    = '0;
          ovf_d   = 1'b0;
          stale_d = 1'b1;
        end else if (is_accum) begin
          // drop the pixel once the count is at its limit
          if (pc_full) begin
            ovf_d = 1'b1;
          end else begin
            pc_d    = pc_q + 1'b1;
            stale_d = 1'b1;
          end
        end else if (is_map) begin
          res_valid_d = pc_zero || !stale_q;
          res_empty_d = pc_zero;
        end
      end
      ST_RB_SUM: begin
        running_d = running_q + bin_rd;
      end
      ST_RB_DIV: begin
        if (div_done) begin
          if (idx_q == LAST_LVL) begin
            idx_d   = '0;
            stale_d = 1'b0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ST_RB_LOOK: begin
        res_valid_d = 1'b1;
      end
      default: begin
        idx_d = idx_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      idx_q       <= '0;
      pc_q        <= '0;
      ovf_q       <= 1'b0;
      stale_q     <= 1'b1;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      pc_q        <= pc_d;
      ovf_q       <= ovf_d;
      stale_q     <= stale_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    running_q   <= running_d;
    res_empty_q <= res_empty_d;
    res_ovf_q   <= res_ovf_d;
    if (accept) begin
      lvl_q <= lvl_in;
    end
  end

  // Remap table: one write port for the rebuild, one registered read port
  always_ff @(posedge clk_i) begin
    if (remap_we) begin
      remap_mem[idx_q] <= div_quot;
    end
    if (remap_re) begin
      remap_rd_q <= remap_mem[remap_raddr];
    end
  end

  assign res_valid_o           = res_valid_q;
  assign res_o.equalized_level = res_empty_q ? '0 : remap_rd_q;
  assign res_o.empty_res       = res_empty_q;
  assign res_o.overflow        = res_ovf_q;

endmodule

>>> src/he_checker.sv
`timescale 1ns / 1ps

module he_checker import he_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start_i,
  input logic    busy_i,
  input he_req_t req_i,
  input logic    res_valid_i,
  input he_res_t res_i
);

  // Only a map produces a word in the following cycle
  a_no_res_after_other: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_i && (req_i.action != ACT_MAP) |=> !res_valid_i)
    else $error("result word after a non-map command");

  // An empty histogram answers with level zero
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_i.empty_res |-> (res_i.equalized_level == '0))
    else $error("empty result with nonzero level");

  // A clear starts the sweep
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_i && (req_i.action == ACT_CLEAR) |=> busy_i)
    else $error("clear accepted without sweep");

  // A result word never appears while the block is rebuilding or sweeping
  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> !busy_i)
    else $error("result word while busy");

endmodule

bind histogram_equalizer he_checker u_he_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start),
  .busy_i      (busy),
  .req_i       (req_i),
  .res_valid_i (res_valid_o),
  .res_i       (res_o)
);
